// File: rtl/tpm_pkg.sv
// Shared types, phase codes and constants of the telemetry poll master.
package tpm_pkg;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_REQ_GPS  = 3'd1;
  localparam logic [2:0] PH_WAIT_GPS = 3'd2;
  localparam logic [2:0] PH_REQ_RX   = 3'd3;
  localparam logic [2:0] PH_WAIT_RX  = 3'd4;
  localparam logic [2:0] PH_UPDATE   = 3'd5;

  localparam logic [15:0] WAIT_TIME_RESET = 16'd800;

  localparam logic [3:0] REQ_LAST_IDX = 4'd8;

  // wait from a stored coordinate change until the conversion has settled
  localparam logic [2:0] CONV_LATENCY = 3'd6;

  typedef struct packed {
    logic valid;
    logic record;
    logic rx_req;
  } load_t;

  typedef struct packed {
    logic [31:0] latitude_e7;
    logic [31:0] longitude_e7;
    logic [7:0]  satellites;
    logic [7:0]  fix_kind;
    logic [12:0] altitude_dm;
    logic [15:0] ground_speed;
    logic [15:0] course;
    logic [14:0] battery_mv;
    logic [7:0]  signal_strength;
  } rec_t;

  function automatic logic [7:0] req_byte(input logic rx_req, input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h03;
      4'd2:    b = 8'hfc;
      4'd3:    b = 8'h00;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h04;
      4'd6:    b = rx_req ? 8'h34 : 8'h38;
      4'd7:    b = rx_req ? 8'h13 : 8'h9f;
      4'd8:    b = rx_req ? 8'hba : 8'h7b;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/tpm_deg_conv.sv
// Pipelined degree-minute to degrees x 1e7 conversion of one coordinate.
module tpm_deg_conv (
  input  logic        clk,
  input  logic [15:0] hi,
  input  logic [15:0] lo,
  output logic [31:0] deg_e7
);

  localparam logic [32:0] DIV100_MUL = 33'd83887;
  localparam logic [60:0] DIV15_MUL  = 61'd2290649225;
  localparam logic [31:0] E7         = 32'd10000000;

  logic [32:0] q_prod;
  logic [60:0] d_prod;

  logic [9:0]  q_r;
  logic [15:0] hi_r;
  logic [25:0] le3_r1, le3_r2, le3_r3;
  logic [6:0]  r_r;
  logic [31:0] qe7_r2, qe7_r3, qe7_r4, qe7_r5;
  logic [29:0] re7_r;
  logic [30:0] v_r;
  logic [24:0] d_r;

  assign q_prod = {17'd0, hi} * DIV100_MUL;
  // floor(v / 60) = floor((v / 4) / 15)
  assign d_prod = {32'd0, v_r[30:2]} * DIV15_MUL;

  always_ff @(posedge clk) begin
    q_r    <= q_prod[32:23];
    hi_r   <= hi;
    le3_r1 <= {10'd0, lo} * 26'd1000;

    r_r    <= 7'(hi_r - {6'd0, q_r} * 16'd100);
    qe7_r2 <= {22'd0, q_r} * E7;
    le3_r2 <= le3_r1;

    re7_r  <= {23'd0, r_r} * 30'(E7);
    qe7_r3 <= qe7_r2;
    le3_r3 <= le3_r2;

    v_r    <= {1'b0, re7_r} + {5'd0, le3_r3};
    qe7_r4 <= qe7_r3;

    d_r    <= d_prod[59:35];
    qe7_r5 <= qe7_r4;

    deg_e7 <= {7'd0, d_r} + qe7_r5;
  end

endmodule

// File: rtl/tpm_out_stage.sv
// Result register with the nine-byte request sequencer.
module tpm_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  tpm_pkg::load_t     ld,
  input  tpm_pkg::rec_t      rec_in,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [7:0]         tx_byte,
  output logic               last,
  output tpm_pkg::rec_t      rec_out
);

  logic          valid_q;
  logic          kind_q;
  logic          rx_q;
  logic [3:0]    idx;
  tpm_pkg::rec_t rec_q;
  logic          pop;
  logic          done;

  assign last     = kind_q || (idx == tpm_pkg::REQ_LAST_IDX);
  assign pop      = valid_q && out_ready;
  assign done     = pop && last;
  assign can_load = !valid_q || done;

  assign out_valid = valid_q;
  assign kind      = kind_q;
  assign tx_byte   = kind_q ? 8'h00 : tpm_pkg::req_byte(rx_q, idx);
  assign rec_out   = rec_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      idx     <= 4'd0;
    end else if (ld.valid) begin
      valid_q <= 1'b1;
      idx     <= 4'd0;
    end else if (done) begin
      valid_q <= 1'b0;
    end else if (pop) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.valid) begin
      kind_q <= ld.record;
      rx_q   <= ld.rx_req;
      rec_q  <= ld.record ? rec_in : '0;
    end
  end

endmodule

// File: rtl/telemetry_poll_master_core.sv
// Telemetry poll master: phase control, frame capture and result assembly.
// An accepted item that causes results shows its first one in the cycle after acceptance.
// A request item gives nine results, one per cycle while out_ready is high; a new item
// is taken in every cycle except while results are still held on the output and while
// the coordinate conversion pipeline settles after a GPS frame completes.
// Synchronous reset clears phase, counters and stored frames and starts that settling wait.
module telemetry_poll_master_core #(
  parameter int GPS_FRAME_BYTES = 51,
  parameter int RX_FRAME_BYTES  = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  rx_byte,
  input  logic        link_up,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] wait_time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic [31:0] latitude_e7,
  output logic [31:0] longitude_e7,
  output logic [7:0]  satellites,
  output logic [7:0]  fix_kind,
  output logic [12:0] altitude_dm,
  output logic [15:0] ground_speed,
  output logic [15:0] course,
  output logic [14:0] battery_mv,
  output logic [7:0]  signal_strength
);

  localparam int MAX_BYTES = (GPS_FRAME_BYTES > RX_FRAME_BYTES) ? GPS_FRAME_BYTES
                                                                : RX_FRAME_BYTES;
  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam logic [CNT_W-1:0] GPS_LEN = CNT_W'(GPS_FRAME_BYTES);
  localparam logic [CNT_W-1:0] RX_LEN  = CNT_W'(RX_FRAME_BYTES);

  logic [15:0]      wait_time;
  logic [2:0]       phase, phase_next;
  logic [15:0]      elapsed, elapsed_inc, elapsed_next;
  logic [CNT_W-1:0] byte_count, count_inc, count_next;
  logic             fresh, fresh_next;
  logic [2:0]       settle;

  // frame bytes in flight
  logic [15:0] spd_w, alt_w, lat_hi_w, lat_lo_w, lon_hi_w, lon_lo_w, crs_w;
  logic [7:0]  sat_b, fix_b;

  // last complete frames
  logic [15:0] lat_hi, lat_lo, lon_hi, lon_lo;
  logic [15:0] spd, crs, alt;
  logic [7:0]  sat, fix, batt, rssi;

  logic             accept, in_wait, store, timed_out, gps_take, rx_take;
  logic [CNT_W-1:0] frame_len;
  logic [31:0]      lat_deg, lon_deg;
  logic [31:0]      alt_prod;
  logic             can_load;
  tpm_pkg::load_t   ld;
  tpm_pkg::rec_t    rec_in, rec_out;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_load && (settle == 3'd0);
  assign accept    = in_valid && in_ready;

  assign in_wait   = (phase == tpm_pkg::PH_WAIT_GPS) || (phase == tpm_pkg::PH_WAIT_RX);
  assign frame_len = (phase == tpm_pkg::PH_WAIT_GPS) ? GPS_LEN : RX_LEN;
  assign store     = func && in_wait && (byte_count < frame_len);

  assign elapsed_inc = (!func && elapsed != 16'hffff) ? elapsed + 16'd1 : elapsed;
  assign count_inc   = store ? byte_count + CNT_W'(1) : byte_count;
  assign timed_out   = elapsed_inc > wait_time;

  always_comb begin
    phase_next   = phase;
    elapsed_next = elapsed_inc;
    count_next   = count_inc;
    fresh_next   = fresh;
    gps_take     = 1'b0;
    rx_take      = 1'b0;
    ld           = '0;
    case (phase)
      tpm_pkg::PH_REQ_GPS: begin
        if (timed_out) begin
          phase_next   = tpm_pkg::PH_WAIT_GPS;
          elapsed_next = 16'd0;
          count_next   = '0;
          ld.valid     = 1'b1;
        end
      end
      tpm_pkg::PH_WAIT_GPS: begin
        if (count_inc >= GPS_LEN) begin
          gps_take   = 1'b1;
          fresh_next = 1'b1;
          phase_next = tpm_pkg::PH_REQ_RX;
        end else if (timed_out) begin
          phase_next = tpm_pkg::PH_REQ_RX;
        end
      end
      tpm_pkg::PH_REQ_RX: begin
        if (timed_out) begin
          phase_next   = tpm_pkg::PH_WAIT_RX;
          elapsed_next = 16'd0;
          count_next   = '0;
          ld.valid     = 1'b1;
          ld.rx_req    = 1'b1;
        end
      end
      tpm_pkg::PH_WAIT_RX: begin
        if (count_inc >= RX_LEN) begin
          rx_take    = 1'b1;
          fresh_next = 1'b1;
          phase_next = tpm_pkg::PH_UPDATE;
        end else if (timed_out) begin
          phase_next = tpm_pkg::PH_UPDATE;
        end
      end
      tpm_pkg::PH_UPDATE: begin
        ld.valid   = fresh;
        ld.record  = 1'b1;
        fresh_next = 1'b0;
        phase_next = tpm_pkg::PH_IDLE;
      end
      default: begin
        phase_next = link_up ? tpm_pkg::PH_REQ_GPS : tpm_pkg::PH_IDLE;
      end
    endcase
    ld.valid = ld.valid && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_time  <= tpm_pkg::WAIT_TIME_RESET;
      phase      <= tpm_pkg::PH_IDLE;
      elapsed    <= 16'd0;
      byte_count <= '0;
      fresh      <= 1'b0;
      settle     <= tpm_pkg::CONV_LATENCY;
      lat_hi     <= 16'd0;
      lat_lo     <= 16'd0;
      lon_hi     <= 16'd0;
      lon_lo     <= 16'd0;
      spd        <= 16'd0;
      crs        <= 16'd0;
      alt        <= 16'd0;
      sat        <= 8'd0;
      fix        <= 8'd0;
      batt       <= 8'd0;
      rssi       <= 8'd0;
    end else begin
      if (cfg_valid) begin
        wait_time <= wait_time_ms;
      end
      if (accept) begin
        phase      <= phase_next;
        elapsed    <= elapsed_next;
        byte_count <= count_next;
        fresh      <= fresh_next;
      end
      if (accept && gps_take) begin
        settle <= tpm_pkg::CONV_LATENCY;
        lat_hi <= lat_hi_w;
        lat_lo <= lat_lo_w;
        lon_hi <= lon_hi_w;
        lon_lo <= lon_lo_w;
        spd    <= spd_w;
        crs    <= crs_w;
        alt    <= alt_w;
        sat    <= sat_b;
        fix    <= fix_b;
      end else if (settle != 3'd0) begin
        settle <= settle - 3'd1;
      end
      if (accept && rx_take) begin
        rssi <= alt_w[7:0];
        batt <= alt_w[15:8];
      end
    end
  end

  // little-endian words picked out of the arriving frame
  always_ff @(posedge clk) begin
    if (accept && store) begin
      case (byte_count)
        CNT_W'(9):  spd_w[7:0]     <= rx_byte;
        CNT_W'(10): spd_w[15:8]    <= rx_byte;
        CNT_W'(13): alt_w[7:0]     <= rx_byte;
        CNT_W'(14): alt_w[15:8]    <= rx_byte;
        CNT_W'(15): lat_hi_w[7:0]  <= rx_byte;
        CNT_W'(16): lat_hi_w[15:8] <= rx_byte;
        CNT_W'(17): lat_lo_w[7:0]  <= rx_byte;
        CNT_W'(18): lat_lo_w[15:8] <= rx_byte;
        CNT_W'(19): lon_hi_w[7:0]  <= rx_byte;
        CNT_W'(20): lon_hi_w[15:8] <= rx_byte;
        CNT_W'(21): lon_lo_w[7:0]  <= rx_byte;
        CNT_W'(22): lon_lo_w[15:8] <= rx_byte;
        CNT_W'(23): crs_w[7:0]     <= rx_byte;
        CNT_W'(24): crs_w[15:8]    <= rx_byte;
        CNT_W'(31): sat_b          <= rx_byte;
        CNT_W'(32): fix_b          <= rx_byte;
        default: ;
      endcase
    end
  end

  tpm_deg_conv u_lat (
    .clk    (clk),
    .hi     (lat_hi),
    .lo     (lat_lo),
    .deg_e7 (lat_deg)
  );

  tpm_deg_conv u_lon (
    .clk    (clk),
    .hi     (lon_hi),
    .lo     (lon_lo),
    .deg_e7 (lon_deg)
  );

  // divide by ten through the reciprocal 52429 / 2^19
  assign alt_prod = {16'd0, alt} * 32'd52429;

  always_comb begin
    rec_in.latitude_e7     = lat_deg;
    rec_in.longitude_e7    = lon_deg;
    rec_in.satellites      = sat;
    rec_in.fix_kind        = fix;
    rec_in.altitude_dm     = alt_prod[31:19];
    rec_in.ground_speed    = spd;
    rec_in.course          = crs;
    rec_in.battery_mv      = {7'd0, batt} * 15'd100;
    rec_in.signal_strength = rssi;
  end

  tpm_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .ld        (ld),
    .rec_in    (rec_in),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .tx_byte   (tx_byte),
    .last      (last),
    .rec_out   (rec_out)
  );

  assign latitude_e7     = rec_out.latitude_e7;
  assign longitude_e7    = rec_out.longitude_e7;
  assign satellites      = rec_out.satellites;
  assign fix_kind        = rec_out.fix_kind;
  assign altitude_dm     = rec_out.altitude_dm;
  assign ground_speed    = rec_out.ground_speed;
  assign course          = rec_out.course;
  assign battery_mv      = rec_out.battery_mv;
  assign signal_strength = rec_out.signal_strength;

endmodule
